>>> sv/wctl_pkg.sv
// Package for the write-back cache tag controller.
// Holds field widths, register and mode codes, the line record and state type.
// No dependencies; every other file uses it.
package wctl_pkg;

   localparam int DEF_MAX_LINES = 64;
   localparam int ADDR_W        = 32;
   localparam int TAG_W         = 30;
   localparam int STAMP_W       = 32;
   localparam int WAY_OUT_W     = 6;
   localparam int LOG_W         = 4;
   localparam int OFF_W         = 5;
   localparam int SHIFT_W       = 6;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 5;

   localparam logic [OFF_W-1:0] OFF_MIN = 5'd2;
   localparam logic [OFF_W-1:0] OFF_MAX = 5'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_ASSOC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LINES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK = 2'd2;

   typedef enum logic [1:0] {
      ASSOC_DIRECT = 2'd0,
      ASSOC_FULL   = 2'd1,
      ASSOC_TWO    = 2'd2,
      ASSOC_FOUR   = 2'd3
   } assoc_type;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_SCAN   = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   typedef struct packed {
      logic               valid;
      logic               dirty;
      logic [TAG_W-1:0]   tag;
      logic [STAMP_W-1:0] stamp;
   } line_type;

endpackage

>>> sv/wctl_if.sv
// Channel interfaces of the cache tag controller: access, result and register write.
// Depends on wctl_pkg for field widths.
interface wctl_req_if;
   logic                       valid;
   logic                       ready;
   logic                       mode;
   logic [wctl_pkg::ADDR_W-1:0] address;
   modport source (output valid, output mode, output address, input ready);
   modport sink   (input valid, input mode, input address, output ready);
endinterface

interface wctl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [wctl_pkg::WAY_OUT_W-1:0] way_used;
   logic                          writeback_valid;
   logic [wctl_pkg::ADDR_W-1:0]    writeback_address;
   modport source (output valid, output hit, output way_used, output writeback_valid,
                   output writeback_address, input ready);
   modport sink   (input valid, input hit, input way_used, input writeback_valid,
                   input writeback_address, output ready);
endinterface

interface wctl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [wctl_pkg::CSR_IDX_W-1:0]  index;
   logic [wctl_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/writeback_cache_tag_lru.sv
// Top level of the write-back, write-allocate cache tag controller with LRU victim choice.
// Depends on wctl_pkg and the channel interfaces in wctl_if.sv.
//
// One access word is taken at a time. After acceptance a sequencer reads the set's lines
// from a line memory with separate read and write ports, one way per cycle, and a shared
// tag and stamp compare finds the hit, the lowest free way and the oldest way in the same
// pass; the update step then writes the line into the memory. The result sits in an
// output register, so the next access is taken while it waits. After reset and after every
// write to the associativity, line-count or block register a clearing pass empties the
// line memory; no access is taken meanwhile, register writes always are.
module writeback_cache_tag_lru #(
   parameter int MAX_LINES = wctl_pkg::DEF_MAX_LINES
) (
   input logic         clock,
   input logic         reset,
   wctl_req_if.sink    req_ch,
   wctl_rsp_if.source  rsp_ch,
   wctl_csr_if.sink    csr_ch
);
   import wctl_pkg::*;

   localparam int LW   = $clog2(MAX_LINES);
   localparam int MAXL = $clog2(MAX_LINES + 1) - 1;
   localparam logic [LOG_W-1:0] MAXL_L   = LOG_W'(MAXL);
   localparam logic [LW-1:0]    CLR_LAST = LW'(MAX_LINES - 1);

   line_type          mem [MAX_LINES];
   line_type          q_ff;

   state_type         state_ff, state_in;
   assoc_type         assoc_ff, assoc_in;
   logic [2:0]        ll_ff, ll_in;
   logic [OFF_W-1:0]  bbl_ff, bbl_in;
   logic [STAMP_W-1:0] count_ff, count_in;
   logic [LW-1:0]     clr_ff, clr_in;

   logic              mode_ff, mode_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [LW-1:0]     set_ff, set_in;

   logic [LW:0]       iss_ff, iss_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [LW-1:0]     chk_way_ff, chk_way_in;
   logic              hit_fnd_ff, hit_fnd_in;
   logic [LW-1:0]     hit_way_ff, hit_way_in;
   logic              hit_dirty_ff, hit_dirty_in;
   logic              inv_fnd_ff, inv_fnd_in;
   logic [LW-1:0]     inv_way_ff, inv_way_in;
   logic [LW-1:0]     vic_way_ff, vic_way_in;
   logic [STAMP_W-1:0] vic_stamp_ff, vic_stamp_in;
   logic [TAG_W-1:0]  vic_tag_ff, vic_tag_in;
   logic              vic_dirty_ff, vic_dirty_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_hit_ff, rsp_hit_in;
   logic [WAY_OUT_W-1:0] rsp_way_ff, rsp_way_in;
   logic              rsp_wb_ff, rsp_wb_in;
   logic [ADDR_W-1:0] rsp_wba_ff, rsp_wba_in;

   logic [LOG_W-1:0]  ll_eff, wl_raw, wl, idx;
   logic [OFF_W-1:0]  off;
   logic [SHIFT_W-1:0] shift_t;
   logic [LW:0]       ways;
   logic [LW-1:0]     base, rd_line, sel_way;
   logic [LW+WAY_OUT_W-1:0] way_ext;
   logic [ADDR_W-1:0] vt32, st32;
   logic              req_acc, rsp_acc, csr_acc, csr_flush, upd_fire, wb;
   logic              mem_we;
   logic [LW-1:0]     mem_wa;
   line_type          mem_wd;

   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_acc = rsp_ch.valid && rsp_ch.ready;
   assign csr_acc = csr_ch.valid && csr_ch.ready;

   assign req_ch.ready = (state_ff == ST_IDLE) && !csr_ch.valid;
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.hit               = rsp_hit_ff;
   assign rsp_ch.way_used          = rsp_way_ff;
   assign rsp_ch.writeback_valid   = rsp_wb_ff;
   assign rsp_ch.writeback_address = rsp_wba_ff;

   // geometry from the registers
   always_comb begin
      ll_eff = (LOG_W'(ll_ff) > MAXL_L) ? MAXL_L : LOG_W'(ll_ff);
      unique case (assoc_ff)
         ASSOC_DIRECT: wl_raw = LOG_W'(0);
         ASSOC_FULL:   wl_raw = ll_eff;
         ASSOC_TWO:    wl_raw = LOG_W'(1);
         ASSOC_FOUR:   wl_raw = LOG_W'(2);
         default:      wl_raw = LOG_W'(0);
      endcase
      wl  = (wl_raw > ll_eff) ? ll_eff : wl_raw;
      idx = ll_eff - wl;
      if (bbl_ff < OFF_MIN) begin
         off = OFF_MIN;
      end else if (bbl_ff > OFF_MAX) begin
         off = OFF_MAX;
      end else begin
         off = bbl_ff;
      end
      shift_t = SHIFT_W'(off) + SHIFT_W'(idx);
      ways    = (LW + 1)'(1) << wl;
   end

   always_comb begin
      base    = set_ff << wl;
      rd_line = base | iss_ff[LW-1:0];
      sel_way = hit_fnd_ff ? hit_way_ff : (inv_fnd_ff ? inv_way_ff : vic_way_ff);
      way_ext = {{WAY_OUT_W{1'b0}}, sel_way};
      wb      = !hit_fnd_ff && !inv_fnd_ff && vic_dirty_ff;
      vt32    = ADDR_W'(vic_tag_ff);
      st32    = ADDR_W'(set_ff);
      upd_fire = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ch.ready);
   end

   always_comb begin
      csr_flush = 1'b0;
      assoc_in  = assoc_ff;
      ll_in     = ll_ff;
      bbl_in    = bbl_ff;
      if (csr_acc) begin
         unique case (csr_ch.index)
            CSR_ASSOC: begin
               assoc_in  = assoc_type'(csr_ch.data[1:0]);
               csr_flush = 1'b1;
            end
            CSR_LINES: begin
               ll_in     = csr_ch.data[2:0];
               csr_flush = 1'b1;
            end
            CSR_BLOCK: begin
               bbl_in    = csr_ch.data;
               csr_flush = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      mode_in      = mode_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      iss_in       = iss_ff;
      chk_vld_in   = 1'b0;
      chk_way_in   = chk_way_ff;
      hit_fnd_in   = hit_fnd_ff;
      hit_way_in   = hit_way_ff;
      hit_dirty_in = hit_dirty_ff;
      inv_fnd_in   = inv_fnd_ff;
      inv_way_in   = inv_way_ff;
      vic_way_in   = vic_way_ff;
      vic_stamp_in = vic_stamp_ff;
      vic_tag_in   = vic_tag_ff;
      vic_dirty_in = vic_dirty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_acc;
      rsp_hit_in   = rsp_hit_ff;
      rsp_way_in   = rsp_way_ff;
      rsp_wb_in    = rsp_wb_ff;
      rsp_wba_in   = rsp_wba_ff;
      mem_we       = 1'b0;
      mem_wa       = clr_ff;
      mem_wd       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + LW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               mode_in    = req_ch.mode;
               tag_in     = TAG_W'(req_ch.address >> shift_t);
               set_in     = LW'((req_ch.address >> off) & ((ADDR_W'(1) << idx) - ADDR_W'(1)));
               count_in   = count_ff + STAMP_W'(1);
               iss_in     = '0;
               hit_fnd_in = 1'b0;
               inv_fnd_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff < ways) begin
               chk_vld_in = 1'b1;
               chk_way_in = iss_ff[LW-1:0];
               iss_in     = iss_ff + (LW + 1)'(1);
            end else if (!chk_vld_ff) begin
               state_in = ST_UPDATE;
            end
            if (chk_vld_ff) begin
               if (q_ff.valid && (q_ff.tag == tag_ff) && !hit_fnd_ff) begin
                  hit_fnd_in   = 1'b1;
                  hit_way_in   = chk_way_ff;
                  hit_dirty_in = q_ff.dirty;
               end
               if (!q_ff.valid && !inv_fnd_ff) begin
                  inv_fnd_in = 1'b1;
                  inv_way_in = chk_way_ff;
               end
               if ((chk_way_ff == '0) || (q_ff.stamp < vic_stamp_ff)) begin
                  vic_way_in   = chk_way_ff;
                  vic_stamp_in = q_ff.stamp;
                  vic_tag_in   = q_ff.tag;
                  vic_dirty_in = q_ff.dirty;
               end
            end
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               mem_we       = 1'b1;
               mem_wa       = base | sel_way;
               mem_wd.valid = 1'b1;
               mem_wd.dirty = hit_fnd_ff ? (hit_dirty_ff | mode_ff) : mode_ff;
               mem_wd.tag   = tag_ff;
               mem_wd.stamp = count_ff;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_fnd_ff;
               rsp_way_in   = way_ext[WAY_OUT_W-1:0];
               rsp_wb_in    = wb;
               rsp_wba_in   = wb ? ((vt32 << shift_t) + (st32 << off)) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      // restart the clearing sweep and the stamp counter
      if (csr_flush) begin
         state_in   = ST_CLEAR;
         clr_in     = '0;
         count_in   = '0;
         chk_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      q_ff <= mem[rd_line];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         assoc_ff     <= ASSOC_DIRECT;
         ll_ff        <= 3'd6;
         bbl_ff       <= OFF_MIN;
         count_ff     <= '0;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         assoc_ff     <= assoc_in;
         ll_ff        <= ll_in;
         bbl_ff       <= bbl_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      tag_ff       <= tag_in;
      set_ff       <= set_in;
      iss_ff       <= iss_in;
      chk_way_ff   <= chk_way_in;
      hit_fnd_ff   <= hit_fnd_in;
      hit_way_ff   <= hit_way_in;
      hit_dirty_ff <= hit_dirty_in;
      inv_fnd_ff   <= inv_fnd_in;
      inv_way_ff   <= inv_way_in;
      vic_way_ff   <= vic_way_in;
      vic_stamp_ff <= vic_stamp_in;
      vic_tag_ff   <= vic_tag_in;
      vic_dirty_ff <= vic_dirty_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_way_ff   <= rsp_way_in;
      rsp_wb_ff    <= rsp_wb_in;
      rsp_wba_ff   <= rsp_wba_in;
   end

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("result word raised outside the update step");

   a_hit_no_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_hit_ff && rsp_wb_ff))
      else $error("hit reported with a write-back");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      csr_acc && (csr_ch.index == CSR_ASSOC || csr_ch.index == CSR_LINES ||
                  csr_ch.index == CSR_BLOCK) |=> state_ff == ST_CLEAR && count_ff == '0)
      else $error("register word did not start a clearing pass");

   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_IDLE) |-> !mem_we)
      else $error("line memory written outside clear or update");

endmodule

>>> tb/sv/wctl_checker.sv
`timescale 1ns / 100ps
// Checker for the cache tag controller. It watches the access, result and register channels,
// predicts every result from its own tag, valid, dirty and stamp copy, and counts mismatches.
// Depends on wctl_pkg and the channel interfaces in wctl_if.sv.
module wctl_checker #(
   parameter int MAX_LINES = wctl_pkg::DEF_MAX_LINES
) (
   input  logic clock,
   input  logic reset,
   wctl_req_if  req_ch,
   wctl_rsp_if  rsp_ch,
   wctl_csr_if  csr_ch,
   output int   outstanding,
   output int   fail_count
);
   import wctl_pkg::*;

   typedef struct {
      bit                 hit;
      bit [WAY_OUT_W-1:0] way_used;
      bit                 writeback_valid;
      bit [ADDR_W-1:0]    writeback_address;
   } outcome_type;

   assoc_type          assoc;
   bit [2:0]           lines_log;
   bit [OFF_W-1:0]     block_log;
   bit                 line_valid [MAX_LINES];
   bit                 line_dirty [MAX_LINES];
   bit [TAG_W-1:0]     line_tag   [MAX_LINES];
   bit [STAMP_W-1:0]   line_stamp [MAX_LINES];
   bit [STAMP_W-1:0]   access_count;
   outcome_type        outcome_q[$];
   outcome_type        want;

   task automatic report(string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   function automatic void flush_lines();
      for (int i = 0; i < MAX_LINES; i++) begin
         line_valid[i] = 1'b0;
         line_dirty[i] = 1'b0;
         line_tag[i]   = '0;
         line_stamp[i] = '0;
      end
      access_count = '0;
   endfunction

   function automatic void apply_register(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_ASSOC: assoc = assoc_type'(value[1:0]);
         CSR_LINES: lines_log = value[2:0];
         CSR_BLOCK: block_log = value[4:0];
         default:   return;
      endcase
      flush_lines();
   endfunction

   function automatic void install_line(int unsigned ln, bit [31:0] tag, bit is_write);
      line_tag[ln]   = tag[TAG_W-1:0];
      line_valid[ln] = 1'b1;
      line_dirty[ln] = is_write;
      line_stamp[ln] = access_count;
   endfunction

   function automatic outcome_type predict_access(bit is_write, bit [ADDR_W-1:0] addr);
      outcome_type   res;
      int unsigned   lines, ways, sets, idx_bits, off_bits, base, victim, ln;
      bit [31:0]     set_no, tag;
      res = '{hit: 1'b0, way_used: '0, writeback_valid: 1'b0, writeback_address: '0};
      lines = 1 << lines_log;
      while (lines > MAX_LINES) lines = lines >> 1;
      case (assoc)
         ASSOC_DIRECT: ways = 1;
         ASSOC_FULL:   ways = lines;
         ASSOC_TWO:    ways = 2;
         default:      ways = 4;
      endcase
      if (ways > lines) ways = lines;
      sets = lines / ways;
      idx_bits = 0;
      while ((1 << idx_bits) < sets) idx_bits++;
      off_bits = (block_log < OFF_MIN) ? OFF_MIN : (block_log > OFF_MAX) ? OFF_MAX : block_log;
      set_no = (addr >> off_bits) & ((32'd1 << idx_bits) - 32'd1);
      tag    = addr >> (off_bits + idx_bits);
      base   = set_no * ways;
      access_count++;

      for (int w = 0; w < ways; w++) begin
         ln = base + w;
         if (line_valid[ln] && line_tag[ln] == tag[TAG_W-1:0]) begin
            if (is_write) line_dirty[ln] = 1'b1;
            line_stamp[ln] = access_count;
            res.hit      = 1'b1;
            res.way_used = WAY_OUT_W'(w);
            return res;
         end
      end

      for (int w = 0; w < ways; w++) begin
         ln = base + w;
         if (!line_valid[ln]) begin
            install_line(ln, tag, is_write);
            res.way_used = WAY_OUT_W'(w);
            return res;
         end
      end

      // evict the oldest stamp, lowest way on ties
      victim = 0;
      for (int w = 1; w < ways; w++)
         if (line_stamp[base + w] < line_stamp[base + victim]) victim = w;
      ln = base + victim;
      if (line_dirty[ln]) begin
         res.writeback_valid   = 1'b1;
         res.writeback_address = ({2'b00, line_tag[ln]} << (off_bits + idx_bits))
                                 + (set_no << off_bits);
      end
      install_line(ln, tag, is_write);
      res.way_used = WAY_OUT_W'(victim);
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         assoc      = ASSOC_DIRECT;
         lines_log  = 3'd6;
         block_log  = OFF_MIN;
         fail_count = 0;
         flush_lines();
         outcome_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) apply_register(csr_ch.index, csr_ch.data);
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outcome_q.size() == 0) begin
               report("result word with no access outstanding");
            end else begin
               want = outcome_q.pop_front();
               if (rsp_ch.hit !== want.hit)
                  report($sformatf("hit: got %b, want %b", rsp_ch.hit, want.hit));
               if (rsp_ch.way_used !== want.way_used)
                  report($sformatf("way_used: got %0d, want %0d",
                                   rsp_ch.way_used, want.way_used));
               if (rsp_ch.writeback_valid !== want.writeback_valid)
                  report($sformatf("writeback_valid: got %b, want %b",
                                   rsp_ch.writeback_valid, want.writeback_valid));
               if (rsp_ch.writeback_address !== want.writeback_address)
                  report($sformatf("writeback_address: got %h, want %h",
                                   rsp_ch.writeback_address, want.writeback_address));
            end
         end
         if (req_ch.valid && req_ch.ready)
            outcome_q.push_back(predict_access(req_ch.mode, req_ch.address));
      end
      outstanding <= outcome_q.size();
   end

endmodule

>>> tb/sv/writeback_cache_tag_lru_tb.sv
`timescale 1ns / 100ps
// Testbench top for the cache tag controller: drives accesses with random gaps and register
// writes between phases, stalls the result side, and gives the verdict from the checker's count.
// Depends on wctl_pkg, wctl_if.sv, wctl_checker.sv and the block itself.
module writeback_cache_tag_lru_tb;
   import wctl_pkg::*;

   localparam int MAX_LINES   = DEF_MAX_LINES;
   localparam int SETTLE      = MAX_LINES + 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int N_PHASES    = 10;
   localparam int PHASE_ITEMS = 94;
   localparam int POOL_SIZE   = 16;
   localparam int N_DIRECTED  = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock = 1'b0;
   logic reset;
   int   outstanding, fail_count, quiet_cycles, stall_left;
   bit   source_idle_on, sink_idle_on;

   assoc_type phase_assoc [N_PHASES] = '{ASSOC_DIRECT, ASSOC_FULL, ASSOC_TWO, ASSOC_FOUR,
                                          ASSOC_DIRECT, ASSOC_FOUR, ASSOC_FULL, ASSOC_TWO,
                                          ASSOC_DIRECT, ASSOC_FOUR};
   bit [2:0]  phase_lines [N_PHASES] = '{6, 6, 3, 0, 7, 6, 2, 1, 0, 5};
   bit [4:0]  phase_block [N_PHASES] = '{2, 2, 5, 0, 31, 16, 9, 3, 12, 7};

   bit        directed_write [N_DIRECTED] = '{0, 1, 0, 0, 1, 1, 0, 1,
                                              0, 1, 0, 1, 0, 1, 0, 0};
   bit [31:0] directed_addr  [N_DIRECTED] = '{
      32'h0000_0000, 32'h0000_0003, 32'h0000_0100, 32'h0000_0200,
      32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h0000_00FC, 32'h8000_0000,
      32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0101,
      32'h8000_0000, 32'h5555_5554, 32'hD555_5555, 32'hAAAA_AAA8};

   wctl_req_if req_ch();
   wctl_rsp_if rsp_ch();
   wctl_csr_if csr_ch();

   writeback_cache_tag_lru #(.MAX_LINES(MAX_LINES)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   wctl_checker #(.MAX_LINES(MAX_LINES)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int idle_gap(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 48);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= idle_gap(1'b1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_access(bit is_write, bit [ADDR_W-1:0] addr);
      int gap;
      gap = idle_gap(source_idle_on);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.mode    <= is_write;
      req_ch.address <= addr;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // hold the access side until every result word is back
   task automatic drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(bit [CSR_IDX_W-1:0] idx, bit [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   initial begin
      bit [31:0] low_pattern [4];
      bit [31:0] addr_pool [POOL_SIZE];
      bit [31:0] off_mask, addr;
      int        off_bits;

      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.mode    <= 1'b0;
      req_ch.address <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.index   <= CSR_ASSOC;
      csr_ch.data    <= '0;
      source_idle_on = 1'b1;
      sink_idle_on   = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) begin
            drain();
            repeat (SETTLE) @(posedge clock);
            write_reg(CSR_ASSOC, {3'($urandom_range(0, 7)), 2'(phase_assoc[p])});
            write_reg(CSR_LINES, {2'($urandom_range(0, 3)), phase_lines[p]});
            write_reg(CSR_BLOCK, phase_block[p]);
            if (p == 4) write_reg(CSR_SPARE, 5'($urandom));
            csr_ch.valid <= 1'b0;
         end
         source_idle_on = ($urandom_range(0, 3) != 0);
         sink_idle_on   = ($urandom_range(0, 3) != 0);

         off_bits = (phase_block[p] < OFF_MIN) ? OFF_MIN :
                    (phase_block[p] > OFF_MAX) ? OFF_MAX : phase_block[p];
         off_mask = (32'd1 << off_bits) - 32'd1;
         // few low patterns so that tags pile up in the same sets
         foreach (low_pattern[i]) low_pattern[i] = $urandom & 32'h00FF_FFFF;
         foreach (addr_pool[i])
            addr_pool[i] = ($urandom & 32'hFF00_0000) | low_pattern[$urandom_range(0, 3)];

         if (p == 0)
            for (int i = 0; i < N_DIRECTED; i++) send_access(directed_write[i], directed_addr[i]);

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p == 3 && i == 40) drain();
            if ($urandom_range(0, 99) < 70)
               addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ ($urandom & off_mask);
            else
               addr = $urandom;
            send_access(1'($urandom_range(0, 1)), addr);
         end
      end

      drain();
      repeat (SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> sim.f
sv/wctl_pkg.sv
sv/wctl_if.sv
sv/writeback_cache_tag_lru.sv
tb/sv/wctl_checker.sv
tb/sv/writeback_cache_tag_lru_tb.sv
